FILE: rtl/rlpd_pkg.sv
`timescale 1ns / 1ps

package rlpd_pkg;

    // largest image the size clamp allows
    localparam int unsigned MAX_WIDTH  = 320;
    localparam int unsigned MAX_HEIGHT = 200;

    localparam int unsigned WIDTH_W  = 9;
    localparam int unsigned HEIGHT_W = 8;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned TABLE_W  = 56;

    // color planes
    localparam logic [1:0] PLANE_RED   = 2'd0;
    localparam logic [1:0] PLANE_GREEN = 2'd1;
    localparam logic [1:0] PLANE_BLUE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MONO_MODE    = 2'd2;
    localparam logic [1:0] REG_RUN_TABLE    = 2'd3;

    // reset values of the configuration registers
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(MAX_HEIGHT);

    // one output segment
    typedef struct packed {
        logic [1:0]         plane;
        logic [POS_W-1:0]   start_pixel;
        logic [COUNT_W-1:0] run_count;
        logic [3:0]         level;
        logic               replicate;
        logic               image_done;
        logic               last;
    } seg_t;

    // decoder position in the image
    typedef struct packed {
        logic [1:0]       plane_index;
        logic [POS_W-1:0] pixel_position;
        logic             finished;
    } dec_state_t;

endpackage

FILE: rtl/rlpd_step.sv
`timescale 1ns / 1ps

module rlpd_step (
    input  rlpd_pkg::dec_state_t                   state,
    input  logic [7:0]                             code_byte,
    input  logic [rlpd_pkg::POS_W-1:0]             plane_size,
    input  logic                                   mono_mode,
    input  logic [rlpd_pkg::TABLE_W-1:0]           run_table,
    output rlpd_pkg::seg_t                         seg0,
    output rlpd_pkg::seg_t                         seg1,
    output logic                                   split,
    output rlpd_pkg::dec_state_t                   state_next
);
    import rlpd_pkg::*;

    logic [2:0]         code;
    logic [3:0]         lvl;
    logic [7:0]         table_byte;
    logic [COUNT_W-1:0] run_len;
    logic [POS_W-1:0]   remaining;
    logic               plane_full;
    logic [COUNT_W-1:0] rem;
    logic [COUNT_W-1:0] rem_clip;

    assign code = code_byte[7:5];
    assign lvl  = code_byte[4:1];

    // run length lookup: code 0 is a single pixel
    always_comb
    begin
        case (code)
            3'd1:    table_byte = run_table[7:0];
            3'd2:    table_byte = run_table[15:8];
            3'd3:    table_byte = run_table[23:16];
            3'd4:    table_byte = run_table[31:24];
            3'd5:    table_byte = run_table[39:32];
            3'd6:    table_byte = run_table[47:40];
            3'd7:    table_byte = run_table[55:48];
            default: table_byte = 8'd0;
        endcase
    end

    assign run_len = (code == 3'd0) ? COUNT_W'(1) : ({1'b0, table_byte} + COUNT_W'(1));

    // pixels left in the plane, none when the plane has shrunk below the position
    assign remaining  = (state.pixel_position < plane_size) ?
                        (plane_size - state.pixel_position) : '0;
    assign plane_full = ({{(POS_W-COUNT_W){1'b0}}, run_len} >= remaining);

    // spill into the next plane, limited to one plane
    assign rem      = run_len - remaining[COUNT_W-1:0];
    assign rem_clip = ({{(POS_W-COUNT_W){1'b0}}, rem} > plane_size) ?
                      plane_size[COUNT_W-1:0] : rem;

    // segment selection and state update
    always_comb
    begin
        seg0       = '0;
        seg1       = '0;
        split      = 1'b0;
        state_next = state;

        seg0.plane       = state.plane_index;
        seg0.start_pixel = state.pixel_position;
        seg0.level       = lvl;
        seg0.last        = 1'b1;

        seg1.plane     = state.plane_index + 2'd1;
        seg1.run_count = rem_clip;
        seg1.level     = lvl;
        seg1.last      = 1'b1;

        if (state.finished)
        begin
            // image already complete: one empty done segment
            seg0.level      = 4'd0;
            seg0.image_done = 1'b1;
        end
        else if (!plane_full)
        begin
            seg0.run_count       = run_len;
            state_next.pixel_position = state.pixel_position +
                                        {{(POS_W-COUNT_W){1'b0}}, run_len};
        end
        else if (mono_mode || (state.plane_index >= PLANE_BLUE))
        begin
            // last plane completes the image, any spill is dropped
            seg0.run_count            = remaining[COUNT_W-1:0];
            seg0.replicate            = mono_mode;
            seg0.image_done           = 1'b1;
            state_next.pixel_position = state.pixel_position + remaining;
            state_next.finished       = 1'b1;
        end
        else if (rem == '0)
        begin
            // exact fit closes the plane
            seg0.run_count            = remaining[COUNT_W-1:0];
            state_next.plane_index    = state.plane_index + 2'd1;
            state_next.pixel_position = '0;
        end
        else
        begin
            seg0.run_count            = remaining[COUNT_W-1:0];
            seg0.last                 = 1'b0;
            split                     = 1'b1;
            state_next.plane_index    = state.plane_index + 2'd1;
            state_next.pixel_position = {{(POS_W-COUNT_W){1'b0}}, rem_clip};
        end
    end

endmodule

FILE: rtl/table_run_length_plane_decoder_top.sv
`timescale 1ns / 1ps

// a byte is held in the input register, and its first segment is registered in the output register when it is decoded
// throughput: one byte per cycle while the output is free and no configuration write is pending; a byte that
//   spills into the next plane holds the input side while its second segment leaves the pending register
// a configuration write blocks decoding while the plane size register updates
// reset: asynchronous active-low; red plane, pixel 0, image not finished, registers at defaults
module table_run_length_plane_decoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        code_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        plane,
    output logic [rlpd_pkg::POS_W-1:0]        start_pixel,
    output logic [rlpd_pkg::COUNT_W-1:0]      run_count,
    output logic [3:0]                        level,
    output logic                              replicate,
    output logic                              image_done,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [rlpd_pkg::TABLE_W-1:0]      cfg_data
);
    import rlpd_pkg::*;

    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic                mono_mode_reg;
    logic [TABLE_W-1:0]  run_table_reg;
    logic                cfg_dirty_reg;
    logic [POS_W-1:0]    plane_size_reg;
    logic [POS_W-1:0]    plane_size_next;
    logic [WIDTH_W-1:0]  width_clamp;
    logic [HEIGHT_W-1:0] height_clamp;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;

    dec_state_t          state_reg;
    dec_state_t          state_next;
    seg_t                seg0;
    seg_t                seg1;
    logic                split;

    logic                out_valid_reg;
    seg_t                out_reg;
    logic                seg1_valid_reg;
    seg_t                seg1_reg;

    logic                out_free;
    logic                move_seg1;
    logic                do_step;
    logic                cfg_write;

    // configuration write port
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            mono_mode_reg    <= 1'b0;
            run_table_reg    <= '0;
            cfg_dirty_reg    <= 1'b0;
        end
        else
        begin
            cfg_dirty_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                    REG_MONO_MODE:    mono_mode_reg    <= cfg_data[0];
                    REG_RUN_TABLE:    run_table_reg    <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // clamp sizes and register the plane size
    assign width_clamp  = (image_width_reg == '0) ? WIDTH_W'(1) :
                          (image_width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) :
                          image_width_reg;
    assign height_clamp = (image_height_reg == '0) ? HEIGHT_W'(1) :
                          (image_height_reg > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) :
                          image_height_reg;
    assign plane_size_next = {{(POS_W-WIDTH_W){1'b0}}, width_clamp} *
                             {{(POS_W-HEIGHT_W){1'b0}}, height_clamp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_size_reg <= POS_W'(MAX_WIDTH * MAX_HEIGHT);
        end
        else
        begin
            plane_size_reg <= plane_size_next;
        end
    end

    // handshake control
    assign out_free  = !out_valid_reg || out_ready;
    assign move_seg1 = seg1_valid_reg && out_free;
    assign do_step   = in_valid_reg && !seg1_valid_reg && out_free && !cfg_dirty_reg;
    assign in_ready  = !in_valid_reg || do_step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= code_byte;
        end
    end

    rlpd_step u_step (
        .state      (state_reg),
        .code_byte  (in_byte_reg),
        .plane_size (plane_size_reg),
        .mono_mode  (mono_mode_reg),
        .run_table  (run_table_reg),
        .seg0       (seg0),
        .seg1       (seg1),
        .split      (split),
        .state_next (state_next)
    );

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (do_step)
        begin
            state_reg <= state_next;
        end
    end

    // output register and pending second segment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            seg1_valid_reg <= 1'b0;
        end
        else
        begin
            if (move_seg1 || do_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (move_seg1)
            begin
                seg1_valid_reg <= 1'b0;
            end
            else if (do_step)
            begin
                seg1_valid_reg <= split;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_seg1)
        begin
            out_reg <= seg1_reg;
        end
        else if (do_step)
        begin
            out_reg <= seg0;
        end

        if (do_step)
        begin
            seg1_reg <= seg1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign plane       = out_reg.plane;
    assign start_pixel = out_reg.start_pixel;
    assign run_count   = out_reg.run_count;
    assign level       = out_reg.level;
    assign replicate   = out_reg.replicate;
    assign image_done  = out_reg.image_done;
    assign last        = out_reg.last;

    // a pending second segment always sits behind a shown first one
    assert property (@(posedge clk) disable iff (!rst_n)
        seg1_valid_reg |-> (out_valid_reg && !out_reg.last))
        else $error("pending segment without a non-final segment in the output register");

    // a completed image stays completed
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.finished |=> state_reg.finished)
        else $error("finished flag cleared without reset");

    // plane index never passes blue
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.plane_index != 2'd3)
        else $error("plane index out of range");

    // no decode step in the cycle after a configuration write
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !do_step)
        else $error("decode step used a stale plane size");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rlpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned PHASE_ITEMS  = 194;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum int {ROW_CODE, ROW_TYPED, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [55:0] data;
        seg_t        typed;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           code_byte = 8'd0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           plane;
    logic [POS_W-1:0]     start_pixel;
    logic [COUNT_W-1:0]   run_count;
    logic [3:0]           level;
    logic                 replicate;
    logic                 image_done;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = 2'd0;
    logic [TABLE_W-1:0]   cfg_data = '0;

    // decoder image model
    logic [WIDTH_W-1:0]   model_width = WIDTH_RESET;
    logic [HEIGHT_W-1:0]  model_height = HEIGHT_RESET;
    logic                 model_mono = 1'b0;
    logic [TABLE_W-1:0]   model_table = '0;
    logic [1:0]           cur_plane = PLANE_RED;
    logic [POS_W-1:0]     cur_pos = '0;
    logic                 img_finished = 1'b0;

    seg_t                 expected_segs[$];
    stim_row_t            rows[$];
    idle_mode_t           idle_mode = IDLE_NONE;
    int unsigned          mismatches = 0;
    int unsigned          cycle_count = 0;

    table_run_length_plane_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_byte   (code_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .plane       (plane),
        .start_pixel (start_pixel),
        .run_count   (run_count),
        .level       (level),
        .replicate   (replicate),
        .image_done  (image_done),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // segments produced by one code byte, advances the image position
    function automatic int predict_segments(input logic [7:0] b, output seg_t first,
                                            output seg_t second);
        int unsigned code;
        int unsigned run_len;
        int unsigned w;
        int unsigned h;
        int unsigned psize;
        int unsigned left;
        int unsigned spill;
        code = b[7:5];
        first = '0;
        second = '0;
        first.plane = cur_plane;
        first.start_pixel = cur_pos;
        // image already complete: empty closing segment
        if (img_finished)
        begin
            first.image_done = 1'b1;
            first.last = 1'b1;
            return 1;
        end
        run_len = (code == 0) ? 1 : model_table[8*(code-1) +: 8] + 1;
        w = (model_width == 0) ? 1 : ((model_width > MAX_WIDTH) ? MAX_WIDTH : model_width);
        h = (model_height == 0) ? 1 : ((model_height > MAX_HEIGHT) ? MAX_HEIGHT : model_height);
        psize = w * h;
        left = (cur_pos < psize) ? psize - cur_pos : 0;
        first.level = b[4:1];
        if (run_len < left)
        begin
            first.run_count = COUNT_W'(run_len);
            first.last = 1'b1;
            cur_pos = cur_pos + POS_W'(run_len);
            return 1;
        end
        // run closes the current plane
        spill = run_len - left;
        first.run_count = COUNT_W'(left);
        if (model_mono || cur_plane >= PLANE_BLUE)
        begin
            first.replicate = model_mono;
            first.image_done = 1'b1;
            first.last = 1'b1;
            cur_pos = cur_pos + POS_W'(left);
            img_finished = 1'b1;
            return 1;
        end
        cur_plane = cur_plane + 2'd1;
        if (spill == 0)
        begin
            first.last = 1'b1;
            cur_pos = '0;
            return 1;
        end
        // remainder carries into the next plane, clipped to its size
        second.plane = cur_plane;
        second.start_pixel = '0;
        second.run_count = COUNT_W'((spill > psize) ? psize : spill);
        second.level = b[4:1];
        second.last = 1'b1;
        cur_pos = POS_W'(second.run_count);
        return 2;
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [1:0] idx,
                           input logic [55:0] data, input seg_t typed);
        stim_row_t r;
        r.kind = kind;
        r.idx = idx;
        r.data = data;
        r.typed = typed;
        rows.push_back(r);
    endtask

    // one code byte transaction, with a random gap in front when the idle mode stalls the sender
    task automatic send_code(input logic [7:0] b, input bit use_typed, input seg_t typed);
        seg_t s0;
        seg_t s1;
        int   n;
        int   gap = 0;
        if (idle_mode == IDLE_SEND)
            while ($urandom_range(0, 99) < 48)
                gap++;
        else if (idle_mode == IDLE_BOTH)
            while ($urandom_range(0, 99) < 8)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= b;
        do @(posedge clk); while (!in_ready);
        n = predict_segments(b, s0, s1);
        expected_segs.push_back(use_typed ? typed : s0);
        if (n == 2)
            expected_segs.push_back(s1);
    endtask

    task automatic wait_segments_drained();
        in_valid <= 1'b0;
        while (expected_segs.size() != 0)
            @(posedge clk);
    endtask

    // register write transaction; use it only while the decoder is idle, the task itself does not check this
    task automatic write_reg(input logic [1:0] idx, input logic [55:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  model_width = val[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: model_height = val[HEIGHT_W-1:0];
            REG_MONO_MODE:    model_mono = val[0];
            REG_RUN_TABLE:    model_table = val;
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // result side: stall pattern and compare against the oldest expectation
    always @(posedge clk)
    begin
        seg_t got;
        seg_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {plane, start_pixel, run_count, level, replicate, image_done, last};
            if (expected_segs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected segment: plane %0d start %0d count %0d level %0d",
                             got.plane, got.start_pixel, got.run_count, got.level);
            end
            else
            begin
                want = expected_segs.pop_front();
                if (got.plane !== want.plane || got.start_pixel !== want.start_pixel ||
                    got.run_count !== want.run_count || got.level !== want.level ||
                    got.replicate !== want.replicate || got.image_done !== want.image_done ||
                    got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"segment mismatch: expected pl %0d st %0d cnt %0d lv %0d ",
                                  "rep %b done %b last %b, got pl %0d st %0d cnt %0d lv %0d ",
                                  "rep %b done %b last %b"},
                                 want.plane, want.start_pixel, want.run_count, want.level,
                                 want.replicate, want.image_done, want.last,
                                 got.plane, got.start_pixel, got.run_count, got.level,
                                 got.replicate, got.image_done, got.last);
                end
            end
        end
        case (idle_mode)
            IDLE_RECV: out_ready <= ($urandom_range(0, 99) >= 48);
            IDLE_BOTH: out_ready <= ($urandom_range(0, 99) >= 8);
            default:   out_ready <= 1'b1;
        endcase
    end

    // stimulus
    initial
    begin
        logic [55:0] tbl;
        // directed rows: defaults after reset, every run code, size clamps,
        // position past the plane end with a clipped carry, exact plane fit
        add_row(ROW_TYPED, 2'd0, 56'h00, {PLANE_RED, 16'd0, 9'd1, 4'h0, 3'b001});
        add_row(ROW_TYPED, 2'd0, 56'hFF, {PLANE_RED, 16'd1, 9'd1, 4'hF, 3'b001});
        add_row(ROW_CODE, 2'd0, 56'h1E, '0);
        add_row(ROW_REG, REG_RUN_TABLE, 56'h0, '0);
        add_row(ROW_CODE, 2'd0, 56'hE1, '0);
        add_row(ROW_REG, REG_RUN_TABLE, 56'hFF7F3F0F030100, '0);
        add_row(ROW_CODE, 2'd0, 56'h21, '0);
        add_row(ROW_CODE, 2'd0, 56'h43, '0);
        add_row(ROW_CODE, 2'd0, 56'h65, '0);
        add_row(ROW_CODE, 2'd0, 56'h87, '0);
        add_row(ROW_CODE, 2'd0, 56'hA9, '0);
        add_row(ROW_CODE, 2'd0, 56'hCB, '0);
        add_row(ROW_CODE, 2'd0, 56'hED, '0);
        add_row(ROW_REG, REG_IMAGE_WIDTH, 56'd0, '0);
        add_row(ROW_REG, REG_IMAGE_HEIGHT, 56'd0, '0);
        add_row(ROW_CODE, 2'd0, 56'h6F, '0);
        add_row(ROW_REG, REG_IMAGE_WIDTH, 56'd511, '0);
        add_row(ROW_REG, REG_IMAGE_HEIGHT, 56'd255, '0);
        add_row(ROW_CODE, 2'd0, 56'h2A, '0);
        add_row(ROW_REG, REG_IMAGE_WIDTH, 56'd4, '0);
        add_row(ROW_REG, REG_IMAGE_HEIGHT, 56'd1, '0);
        add_row(ROW_CODE, 2'd0, 56'h44, '0);
        add_row(ROW_REG, REG_IMAGE_WIDTH, 56'd511, '0);
        add_row(ROW_REG, REG_IMAGE_HEIGHT, 56'd255, '0);
        add_row(ROW_REG, REG_MONO_MODE, 56'd0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                wait_segments_drained();
                write_reg(rows[i].idx, rows[i].data);
            end
            else
                send_code(rows[i].data[7:0], rows[i].kind == ROW_TYPED, rows[i].typed);
        end

        // random phases: short runs first so the last plane lasts, then
        // full tables, mono choice and sizes down to zero to close the image
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_segments_drained();
            idle_mode = idle_mode_t'(p % 4);
            tbl = '0;
            if (p < PHASE_COUNT - 2)
                for (int k = 0; k < 7; k++)
                    tbl[8*k +: 8] = 8'($urandom_range(0, 63));
            else if (p == PHASE_COUNT - 1 && $urandom_range(0, 1) == 1)
                tbl = '1;
            else
                tbl = {24'($urandom), 32'($urandom)};
            if (p < PHASE_COUNT - 1)
            begin
                write_reg(REG_IMAGE_WIDTH, 56'($urandom_range(250, 511)));
                write_reg(REG_IMAGE_HEIGHT, 56'($urandom_range(200, 255)));
            end
            else
            begin
                write_reg(REG_IMAGE_WIDTH, 56'($urandom_range(0, 511)));
                write_reg(REG_IMAGE_HEIGHT, 56'($urandom_range(0, 255)));
            end
            write_reg(REG_MONO_MODE,
                      (p < PHASE_COUNT - 2) ? 56'd0 : 56'($urandom_range(0, 1)));
            write_reg(REG_RUN_TABLE, tbl);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_code(8'($urandom_range(0, 255)), 1'b0, '0);
        end

        wait_segments_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_segs.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
